@@ hdl/fcp_pkg.sv @@
// types, constants and the fan curve table for the fan curve pwm controller
package fcp_pkg;

  localparam int CurvePoints = 7;
  localparam int TempMax = 120;
  localparam int LutDepth = 128;
  localparam logic [6:0] DutyFull = 7'd100;
  localparam logic [15:0] Sat16 = 16'hFFFF;

  localparam int CurveTemp [CurvePoints] = '{40, 45, 50, 55, 60, 65, 70};
  localparam int CurveDuty [CurvePoints] = '{30, 40, 50, 60, 70, 85, 100};

  localparam logic [15:0] TimeoutReset = 16'd5000;
  localparam logic [6:0] DutyThrReset = 7'd30;
  localparam logic [15:0] RpmThrReset = 16'd100;
  localparam logic [15:0] DelayReset = 16'd3000;

  typedef enum logic [1:0] {
    OpTick = 2'd0,
    OpSetTemp = 2'd1,
    OpSetManual = 2'd2,
    OpLeaveManual = 2'd3
  } fcp_op_e;

  typedef enum logic [1:0] {
    RegTimeout = 2'd0,
    RegDutyThr = 2'd1,
    RegRpmThr = 2'd2,
    RegDelay = 2'd3
  } fcp_reg_e;

  typedef struct packed {
    logic [15:0] timeout_ms;
    logic [6:0] fault_duty_threshold;
    logic [15:0] fault_rpm_threshold;
    logic [15:0] fault_delay_ms;
  } fcp_cfg_t;

  typedef struct packed {
    logic [1:0] operation;
    logic signed [8:0] temperature_in;
    logic [7:0] manual_percent;
    logic [15:0] fan_rpm;
  } fcp_req_t;

  typedef struct packed {
    logic [6:0] duty_percent;
    logic duty_written;
    logic accepted;
    logic reading_fresh;
    logic stall_fault;
    logic manual_active;
  } fcp_rsp_t;

  typedef struct packed {
    logic [6:0] temp;
    logic has_reading;
    logic [15:0] age;
    logic fresh;
    logic manual;
    logic [6:0] duty;
    logic fault;
    logic armed;
    logic [15:0] elapsed;
  } fcp_state_t;

  typedef logic [6:0] duty_lut_t [LutDepth];

  // duty for every whole degree, truncating interpolation between curve points
  function automatic duty_lut_t build_curve_lut();
    duty_lut_t lut;
    int span;
    int rise;
    int num;
    int q;
    bit found;
    for (int t = 0; t < LutDepth; t++) begin
      if (t <= CurveTemp[0]) begin
        lut[t] = 7'(CurveDuty[0]);
      end else begin
        lut[t] = DutyFull;
        found = 1'b0;
        for (int i = 1; i < CurvePoints; i++) begin
          if (!found && t <= CurveTemp[i]) begin
            found = 1'b1;
            span = CurveTemp[i] - CurveTemp[i-1];
            rise = CurveDuty[i] - CurveDuty[i-1];
            num = (t - CurveTemp[i-1]) * rise;
            q = 0;
            for (int k = 1; k < LutDepth; k++) begin
              if (k * span <= num) q = k;
            end
            if (span == 0) lut[t] = 7'(CurveDuty[i]);
            else lut[t] = 7'(CurveDuty[i-1] + q);
          end
        end
      end
    end
    return lut;
  endfunction

  localparam duty_lut_t CurveLut = build_curve_lut();

endpackage

@@ hdl/fcp_if.sv @@
// request, response and configuration channel interfaces
interface fcp_req_if;
  logic valid;
  logic ready;
  logic [1:0] operation;
  logic signed [8:0] temperature_in;
  logic [7:0] manual_percent;
  logic [15:0] fan_rpm;
  modport source (output valid, output operation, output temperature_in,
                  output manual_percent, output fan_rpm, input ready);
  modport sink (input valid, input operation, input temperature_in,
                input manual_percent, input fan_rpm, output ready);
endinterface

interface fcp_rsp_if;
  logic valid;
  logic ready;
  logic [6:0] duty_percent;
  logic duty_written;
  logic accepted;
  logic reading_fresh;
  logic stall_fault;
  logic manual_active;
  modport source (output valid, output duty_percent, output duty_written, output accepted,
                  output reading_fresh, output stall_fault, output manual_active,
                  input ready);
  modport sink (input valid, input duty_percent, input duty_written, input accepted,
                input reading_fresh, input stall_fault, input manual_active,
                output ready);
endinterface

interface fcp_cfg_if;
  logic valid;
  logic ready;
  logic [1:0] index;
  logic [15:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

@@ hdl/fcp_core.sv @@
// controller state and the per-request evaluation: curve, staleness, stall fault
module fcp_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  fcp_pkg::fcp_req_t   req_i,
  input  fcp_pkg::fcp_cfg_t   cfg_i,
  output fcp_pkg::fcp_rsp_t   rsp_o
);

  fcp_pkg::fcp_state_t state_q, state_d;

  function automatic fcp_pkg::fcp_state_t update_fault(fcp_pkg::fcp_state_t s,
                                                      fcp_pkg::fcp_cfg_t c,
                                                      logic [15:0] rpm);
    fcp_pkg::fcp_state_t r;
    r = s;
    if (s.duty < c.fault_duty_threshold || rpm >= c.fault_rpm_threshold) begin
      r.fault = 1'b0;
      r.armed = 1'b0;
      r.elapsed = '0;
    end else if (!s.armed) begin
      r.armed = 1'b1;
      r.elapsed = '0;
    end else if (s.elapsed >= c.fault_delay_ms) begin
      r.fault = 1'b1;
    end
    return r;
  endfunction

  logic [6:0] curve_duty;
  logic temp_ok;
  logic written;
  logic accepted;
  fcp_pkg::fcp_state_t s;
  logic [6:0] next_duty;

  assign curve_duty = fcp_pkg::CurveLut[state_q.temp];
  assign temp_ok = !req_i.temperature_in[8]
                   && (req_i.temperature_in[7:0] <= 8'(fcp_pkg::TempMax));

  always_comb begin
    s = state_q;
    written = 1'b0;
    accepted = 1'b1;
    next_duty = fcp_pkg::DutyFull;
    case (fcp_pkg::fcp_op_e'(req_i.operation))
      fcp_pkg::OpTick: begin
        if (s.age != fcp_pkg::Sat16) s.age = s.age + 16'd1;
        if (s.armed && s.elapsed != fcp_pkg::Sat16) s.elapsed = s.elapsed + 16'd1;
      end
      fcp_pkg::OpSetTemp: begin
        if (temp_ok) begin
          s.manual = 1'b0;
          s.temp = req_i.temperature_in[6:0];
          s.has_reading = 1'b1;
          s.age = '0;
        end else begin
          accepted = 1'b0;
        end
      end
      fcp_pkg::OpSetManual: begin
        s.manual = 1'b1;
        s.duty = (req_i.manual_percent > 8'(fcp_pkg::DutyFull)) ? fcp_pkg::DutyFull
                                                                : req_i.manual_percent[6:0];
        s.fault = 1'b0;
        s.armed = 1'b0;
        s.elapsed = '0;
        written = 1'b1;
      end
      fcp_pkg::OpLeaveManual: begin
        s.manual = 1'b0;
      end
      default: begin
        s.manual = 1'b0;
      end
    endcase

    // evaluation runs for everything but a manual set or a rejected temperature
    if (req_i.operation != fcp_pkg::OpSetManual && accepted) begin
      if (s.manual) begin
        s = update_fault(s, cfg_i, req_i.fan_rpm);
      end else begin
        s.fresh = s.has_reading && (s.age < cfg_i.timeout_ms);
        // curve_duty reads the table at the stored reading; a new reading reads it at its own value
        if (s.fresh) begin
          next_duty = (req_i.operation == fcp_pkg::OpSetTemp)
                      ? fcp_pkg::CurveLut[s.temp] : curve_duty;
        end
        if (next_duty != s.duty) begin
          s.duty = next_duty;
          written = 1'b1;
        end
        s = update_fault(s, cfg_i, req_i.fan_rpm);
        if (s.fault && s.duty < fcp_pkg::DutyFull) begin
          s.duty = fcp_pkg::DutyFull;
          written = 1'b1;
        end
      end
    end

    state_d = step_i ? s : state_q;
    rsp_o.duty_percent = s.duty;
    rsp_o.duty_written = written;
    rsp_o.accepted = accepted;
    rsp_o.reading_fresh = s.fresh;
    rsp_o.stall_fault = s.fault;
    rsp_o.manual_active = s.manual;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '{temp: '0, has_reading: 1'b0, age: '0, fresh: 1'b0, manual: 1'b0,
                   duty: fcp_pkg::DutyFull, fault: 1'b0, armed: 1'b0, elapsed: '0};
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ hdl/fan_curve_pwm_with_stall_fault.sv @@
// Fan duty controller top level: request register, evaluation core, response register.
// One request is taken every clock cycle when the response side keeps up; a request waits
// in the request register, then the evaluation core writes the state and the response
// register together in one step, which is held off while the response register still
// holds a response that is not yet taken. The temperature-to-duty curve is a 128-entry
// constant table read in the evaluation cycle.
// Configuration writes are taken in any cycle and must only be made while idle.
module fan_curve_pwm_with_stall_fault (
  input  logic clk_i,
  input  logic rst_ni,
  fcp_req_if.sink   req_i,
  fcp_rsp_if.source rsp_o,
  fcp_cfg_if.sink   cfg_i
);

  fcp_pkg::fcp_cfg_t cfg_q;
  fcp_pkg::fcp_req_t in_q;
  logic in_vld_q, in_vld_d;
  logic out_vld_q, out_vld_d;
  fcp_pkg::fcp_rsp_t out_q;
  fcp_pkg::fcp_rsp_t core_rsp;
  logic step;
  logic req_take;

  assign step = in_vld_q && (!out_vld_q || rsp_o.ready);
  assign req_i.ready = !in_vld_q || step;
  assign req_take = req_i.valid && req_i.ready;
  assign cfg_i.ready = 1'b1;

  assign in_vld_d = req_take ? 1'b1 : (step ? 1'b0 : in_vld_q);
  assign out_vld_d = step ? 1'b1 : (rsp_o.ready ? 1'b0 : out_vld_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{timeout_ms: fcp_pkg::TimeoutReset,
                 fault_duty_threshold: fcp_pkg::DutyThrReset,
                 fault_rpm_threshold: fcp_pkg::RpmThrReset,
                 fault_delay_ms: fcp_pkg::DelayReset};
    end else if (cfg_i.valid) begin
      case (fcp_pkg::fcp_reg_e'(cfg_i.index))
        fcp_pkg::RegTimeout: cfg_q.timeout_ms <= cfg_i.data;
        fcp_pkg::RegDutyThr: cfg_q.fault_duty_threshold <= cfg_i.data[6:0];
        fcp_pkg::RegRpmThr: cfg_q.fault_rpm_threshold <= cfg_i.data;
        fcp_pkg::RegDelay: cfg_q.fault_delay_ms <= cfg_i.data;
        default: cfg_q <= cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_take) begin
      in_q <= '{operation: req_i.operation, temperature_in: req_i.temperature_in,
                manual_percent: req_i.manual_percent, fan_rpm: req_i.fan_rpm};
    end
    if (step) begin
      out_q <= core_rsp;
    end
  end

  fcp_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .req_i  (in_q),
    .cfg_i  (cfg_q),
    .rsp_o  (core_rsp)
  );

  assign rsp_o.valid = out_vld_q;
  assign rsp_o.duty_percent = out_q.duty_percent;
  assign rsp_o.duty_written = out_q.duty_written;
  assign rsp_o.accepted = out_q.accepted;
  assign rsp_o.reading_fresh = out_q.reading_fresh;
  assign rsp_o.stall_fault = out_q.stall_fault;
  assign rsp_o.manual_active = out_q.manual_active;

  a_duty_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid |-> rsp_o.duty_percent <= fcp_pkg::DutyFull)
    else $error("duty above full scale");

  a_fault_forces_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.stall_fault && !rsp_o.manual_active)
      |-> rsp_o.duty_percent == fcp_pkg::DutyFull)
    else $error("fault without full duty outside manual mode");

  a_reject_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && !rsp_o.accepted) |-> !rsp_o.duty_written)
    else $error("rejected temperature rewrote duty");

  a_step_fills_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step |=> out_vld_q)
    else $error("evaluated request lost before the response register");

endmodule

@@ test/tb_fan_curve_pwm_with_stall_fault.sv @@
`timescale 1ns / 100ps
// testbench for the fan curve controller: directed table, a long stall, then random requests against a predictor
module tb_fan_curve_pwm_with_stall_fault;

  localparam int CycleLimit = 800000;
  localparam int RandomPerPhase = 225;
  localparam int DirCount = 24;
  localparam int LongTicks = 100;

  typedef enum int {
    IdleNone,
    IdleSender,
    IdleReceiver,
    IdleBoth
  } idle_mode_e;

  typedef struct packed {
    fcp_pkg::fcp_req_t req;
    logic              preset;
    fcp_pkg::fcp_rsp_t rsp;
  } dir_row_t;

  typedef struct packed {
    logic              preset;
    fcp_pkg::fcp_rsp_t rsp;
  } preset_status_t;

  // preset rows carry a typed-in response, the rest go to the predictor
  localparam dir_row_t DirRows [DirCount] = '{
    '{'{fcp_pkg::OpTick, 9'd0, 8'd0, 16'd5000}, 1'b1, '{7'd100, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0}},
    '{'{fcp_pkg::OpSetTemp, 9'h100, 8'd0, 16'd0}, 1'b1, '{7'd100, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0}},
    '{'{fcp_pkg::OpSetTemp, 9'h0FF, 8'd0, 16'd0}, 1'b1, '{7'd100, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0}},
    '{'{fcp_pkg::OpSetTemp, 9'd121, 8'd0, 16'd0}, 1'b1, '{7'd100, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0}},
    '{'{fcp_pkg::OpSetTemp, 9'h1FF, 8'd0, 16'd0}, 1'b1, '{7'd100, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0}},
    '{'{fcp_pkg::OpSetTemp, 9'd0, 8'd0, 16'd5000}, 1'b1, '{7'd30, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0}},
    '{'{fcp_pkg::OpSetTemp, 9'd120, 8'd0, 16'd5000}, 1'b1,
      '{7'd100, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0}},
    '{'{fcp_pkg::OpSetTemp, 9'd52, 8'd0, 16'd5000}, 1'b0, '0},
    '{'{fcp_pkg::OpSetTemp, 9'd67, 8'd0, 16'd5000}, 1'b0, '0},
    '{'{fcp_pkg::OpSetTemp, 9'd43, 8'd0, 16'd5000}, 1'b0, '0},
    '{'{fcp_pkg::OpSetTemp, 9'd70, 8'd0, 16'd5000}, 1'b0, '0},
    '{'{fcp_pkg::OpSetTemp, 9'd40, 8'd0, 16'hFFFF}, 1'b0, '0},
    '{'{fcp_pkg::OpSetManual, 9'd0, 8'd255, 16'd0}, 1'b1, '{7'd100, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1}},
    '{'{fcp_pkg::OpTick, 9'd0, 8'd0, 16'd0}, 1'b1, '{7'd100, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1}},
    '{'{fcp_pkg::OpSetManual, 9'd0, 8'd0, 16'd0}, 1'b1, '{7'd0, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1}},
    '{'{fcp_pkg::OpTick, 9'd0, 8'd0, 16'd0}, 1'b0, '0},
    '{'{fcp_pkg::OpSetManual, 9'd0, 8'd101, 16'd0}, 1'b0, '0},
    '{'{fcp_pkg::OpLeaveManual, 9'd0, 8'd0, 16'd0}, 1'b0, '0},
    '{'{fcp_pkg::OpTick, 9'd0, 8'd0, 16'd99}, 1'b0, '0},
    '{'{fcp_pkg::OpSetTemp, 9'd121, 8'd0, 16'd0}, 1'b1, '{7'd30, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0}},
    '{'{fcp_pkg::OpSetManual, 9'd0, 8'd50, 16'd0}, 1'b0, '0},
    '{'{fcp_pkg::OpSetTemp, 9'd65, 8'd0, 16'd100}, 1'b0, '0},
    '{'{fcp_pkg::OpLeaveManual, 9'd0, 8'd0, 16'd0}, 1'b0, '0},
    '{'{fcp_pkg::OpTick, 9'h1FF, 8'd255, 16'hFFFF}, 1'b0, '0}
  };

  logic clk_i;
  logic rst_ni;

  fcp_req_if req_bus();
  fcp_rsp_if rsp_bus();
  fcp_cfg_if cfg_bus();

  fan_curve_pwm_with_stall_fault uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_bus),
    .rsp_o (rsp_bus),
    .cfg_i (cfg_bus)
  );

  fcp_pkg::fcp_cfg_t   fan_cfg;
  fcp_pkg::fcp_state_t fan;
  fcp_pkg::fcp_rsp_t   pending_status_q [$];
  preset_status_t      preset_status_q [$];

  int n_accepted = 0;
  int n_checked = 0;
  int n_mismatch = 0;
  int n_faults = 0;
  int n_rewrites = 0;
  int n_cycles = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;
  bit fan_stopped = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [6:0] curve_duty_for(int t);
    int seg;
    if (t <= fcp_pkg::CurveTemp[0]) return 7'(fcp_pkg::CurveDuty[0]);
    for (seg = 1; seg < fcp_pkg::CurvePoints; seg++) begin
      if (t <= fcp_pkg::CurveTemp[seg]) begin
        return 7'(fcp_pkg::CurveDuty[seg-1] + (t - fcp_pkg::CurveTemp[seg-1]) *
                  (fcp_pkg::CurveDuty[seg] - fcp_pkg::CurveDuty[seg-1]) /
                  (fcp_pkg::CurveTemp[seg] - fcp_pkg::CurveTemp[seg-1]));
      end
    end
    return fcp_pkg::DutyFull;
  endfunction

  function automatic void update_stall(logic [15:0] rpm);
    if (fan.duty < fan_cfg.fault_duty_threshold || rpm >= fan_cfg.fault_rpm_threshold) begin
      fan.fault = 1'b0;
      fan.armed = 1'b0;
      fan.elapsed = '0;
    end else if (!fan.armed) begin
      fan.armed = 1'b1;
      fan.elapsed = '0;
    end else if (fan.elapsed >= fan_cfg.fault_delay_ms) begin
      fan.fault = 1'b1;
    end
  endfunction

  function automatic logic evaluate_duty(logic [15:0] rpm);
    logic [6:0] next;
    logic       wr;
    next = fcp_pkg::DutyFull;
    wr = 1'b0;
    if (fan.manual) begin
      update_stall(rpm);
      return 1'b0;
    end
    fan.fresh = fan.has_reading && (fan.age < fan_cfg.timeout_ms);
    if (fan.fresh) next = curve_duty_for(int'(fan.temp));
    if (next != fan.duty) begin
      fan.duty = next;
      wr = 1'b1;
    end
    update_stall(rpm);
    if (fan.fault && fan.duty < fcp_pkg::DutyFull) begin
      fan.duty = fcp_pkg::DutyFull;
      wr = 1'b1;
    end
    return wr;
  endfunction

  function automatic fcp_pkg::fcp_rsp_t predict_fan_status(fcp_pkg::fcp_req_t r);
    fcp_pkg::fcp_rsp_t o;
    int                tval;
    logic [7:0]        pct;
    o = '0;
    o.accepted = 1'b1;
    tval = int'(r.temperature_in);
    case (fcp_pkg::fcp_op_e'(r.operation))
      fcp_pkg::OpTick: begin
        if (fan.age != fcp_pkg::Sat16) fan.age = fan.age + 16'd1;
        if (fan.armed && fan.elapsed != fcp_pkg::Sat16) fan.elapsed = fan.elapsed + 16'd1;
        o.duty_written = evaluate_duty(r.fan_rpm);
      end
      fcp_pkg::OpSetTemp: begin
        if (tval < 0 || tval > fcp_pkg::TempMax) begin
          o.accepted = 1'b0;
        end else begin
          fan.manual = 1'b0;
          fan.temp = 7'(tval);
          fan.has_reading = 1'b1;
          fan.age = '0;
          o.duty_written = evaluate_duty(r.fan_rpm);
        end
      end
      fcp_pkg::OpSetManual: begin
        pct = r.manual_percent;
        if (pct > fcp_pkg::DutyFull) pct = 8'(fcp_pkg::DutyFull);
        fan.manual = 1'b1;
        fan.duty = pct[6:0];
        fan.fault = 1'b0;
        fan.armed = 1'b0;
        fan.elapsed = '0;
        o.duty_written = 1'b1;
      end
      default: begin
        fan.manual = 1'b0;
        o.duty_written = evaluate_duty(r.fan_rpm);
      end
    endcase
    o.duty_percent = fan.duty;
    o.reading_fresh = fan.fresh;
    o.stall_fault = fan.fault;
    o.manual_active = fan.manual;
    return o;
  endfunction

  // fan runs or stops for stretches so stall timing gets exercised
  function automatic fcp_pkg::fcp_req_t random_request();
    fcp_pkg::fcp_req_t r;
    int                pick;
    int                thr;
    int                top;
    thr = int'(fan_cfg.fault_rpm_threshold);
    top = (thr * 2 + 10 > 65535) ? 65535 : thr * 2 + 10;
    r.temperature_in = 9'($urandom);
    r.manual_percent = 8'($urandom);
    if ($urandom_range(0, 99) < 8) fan_stopped = !fan_stopped;
    if ($urandom_range(0, 9) == 0) r.fan_rpm = 16'($urandom);
    else if (fan_stopped) r.fan_rpm = (thr == 0) ? 16'd0 : 16'($urandom_range(0, thr - 1));
    else r.fan_rpm = 16'($urandom_range(thr, top));
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      r.operation = fcp_pkg::OpTick;
    end else if (pick < 80) begin
      r.operation = fcp_pkg::OpSetTemp;
      if ($urandom_range(0, 1) == 0) r.temperature_in = 9'($urandom_range(35, 75));
      else if ($urandom_range(0, 4) != 0)
        r.temperature_in = 9'($urandom_range(0, fcp_pkg::TempMax));
    end else if (pick < 90) begin
      r.operation = fcp_pkg::OpSetManual;
      if ($urandom_range(0, 2) != 0) r.manual_percent = 8'($urandom_range(0, 100));
    end else begin
      r.operation = fcp_pkg::OpLeaveManual;
    end
    return r;
  endfunction

  task automatic set_idling(idle_mode_e m);
    case (m)
      IdleNone: begin
        send_idle_pct = 0;
        stall_pct = 0;
      end
      IdleSender: begin
        send_idle_pct = 53;
        stall_pct = 0;
      end
      IdleReceiver: begin
        send_idle_pct = 0;
        stall_pct = 53;
      end
      default: begin
        send_idle_pct = 13;
        stall_pct = 13;
      end
    endcase
  endtask

  task automatic send_req(fcp_pkg::fcp_req_t r, logic preset, fcp_pkg::fcp_rsp_t rsp);
    preset_status_t p;
    p.preset = preset;
    p.rsp = rsp;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    preset_status_q.push_back(p);
    req_bus.valid <= 1'b1;
    req_bus.operation <= r.operation;
    req_bus.temperature_in <= r.temperature_in;
    req_bus.manual_percent <= r.manual_percent;
    req_bus.fan_rpm <= r.fan_rpm;
    do @(posedge clk_i); while (!req_bus.ready);
  endtask

  task automatic wait_drained();
    req_bus.valid <= 1'b0;
    @(posedge clk_i);
    while (n_checked != n_accepted) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic put_reg(fcp_pkg::fcp_reg_e idx, logic [15:0] val);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data <= val;
    do @(posedge clk_i); while (!cfg_bus.ready);
  endtask

  task automatic write_config(logic [15:0] tmo, logic [6:0] dthr, logic [15:0] rthr,
                              logic [15:0] dly);
    put_reg(fcp_pkg::RegTimeout, tmo);
    put_reg(fcp_pkg::RegDutyThr, {9'd0, dthr});
    put_reg(fcp_pkg::RegRpmThr, rthr);
    put_reg(fcp_pkg::RegDelay, dly);
    cfg_bus.valid <= 1'b0;
  endtask

  task automatic run_phase(idle_mode_e m, logic [15:0] tmo, logic [6:0] dthr,
                           logic [15:0] rthr, logic [15:0] dly);
    wait_drained();
    write_config(tmo, dthr, rthr, dly);
    set_idling(m);
    repeat (RandomPerPhase) send_req(random_request(), 1'b0, '0);
  endtask

  // response side stalls
  initial begin
    rsp_bus.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      rsp_bus.ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  always @(posedge clk_i) begin : check_status
    fcp_pkg::fcp_rsp_t got;
    fcp_pkg::fcp_rsp_t want;
    fcp_pkg::fcp_req_t seen;
    preset_status_t    p;
    if (!rst_ni) begin
      fan_cfg = '{fcp_pkg::TimeoutReset, fcp_pkg::DutyThrReset, fcp_pkg::RpmThrReset,
                  fcp_pkg::DelayReset};
      fan = '0;
      fan.duty = fcp_pkg::DutyFull;
    end else begin
      if (rsp_bus.valid && rsp_bus.ready) begin
        got = '{rsp_bus.duty_percent, rsp_bus.duty_written, rsp_bus.accepted,
                rsp_bus.reading_fresh, rsp_bus.stall_fault, rsp_bus.manual_active};
        n_checked++;
        if (got.stall_fault) n_faults++;
        if (got.duty_written) n_rewrites++;
        if (pending_status_q.size() == 0) begin
          if (n_mismatch < 10) $display("response %0d arrived with nothing pending", n_checked);
          n_mismatch++;
        end else begin
          want = pending_status_q.pop_front();
          if (got.duty_percent !== want.duty_percent || got.duty_written !== want.duty_written ||
              got.accepted !== want.accepted || got.reading_fresh !== want.reading_fresh ||
              got.stall_fault !== want.stall_fault || got.manual_active !== want.manual_active)
          begin
            if (n_mismatch < 10) begin
              $display("response %0d mismatch: expected duty %0d wr %b acc %b fresh %b flt %b man %b",
                       n_checked, want.duty_percent, want.duty_written, want.accepted,
                       want.reading_fresh, want.stall_fault, want.manual_active);
              $display("  actual duty %0d wr %b acc %b fresh %b flt %b man %b",
                       got.duty_percent, got.duty_written, got.accepted,
                       got.reading_fresh, got.stall_fault, got.manual_active);
            end
            n_mismatch++;
          end
        end
      end
      if (cfg_bus.valid && cfg_bus.ready) begin
        case (fcp_pkg::fcp_reg_e'(cfg_bus.index))
          fcp_pkg::RegTimeout: fan_cfg.timeout_ms = cfg_bus.data;
          fcp_pkg::RegDutyThr: fan_cfg.fault_duty_threshold = cfg_bus.data[6:0];
          fcp_pkg::RegRpmThr:  fan_cfg.fault_rpm_threshold = cfg_bus.data;
          fcp_pkg::RegDelay:   fan_cfg.fault_delay_ms = cfg_bus.data;
          default: ;
        endcase
      end
      if (req_bus.valid && req_bus.ready) begin
        seen = '{req_bus.operation, req_bus.temperature_in, req_bus.manual_percent,
                 req_bus.fan_rpm};
        want = predict_fan_status(seen);
        p = preset_status_q.pop_front();
        if (p.preset) want = p.rsp;
        pending_status_q.push_back(want);
        n_accepted++;
      end
    end
  end

  always @(posedge clk_i) begin
    n_cycles <= n_cycles + 1;
    if (n_cycles >= CycleLimit) begin
      $display("run stopped after %0d cycles with %0d responses pending",
               n_cycles, n_accepted - n_checked);
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    fcp_pkg::fcp_req_t r;
    rst_ni <= 1'b0;
    req_bus.valid <= 1'b0;
    req_bus.operation <= fcp_pkg::OpTick;
    req_bus.temperature_in <= '0;
    req_bus.manual_percent <= '0;
    req_bus.fan_rpm <= '0;
    cfg_bus.valid <= 1'b0;
    cfg_bus.index <= fcp_pkg::RegTimeout;
    cfg_bus.data <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    set_idling(IdleNone);
    for (int i = 0; i < DirCount; i++) send_req(DirRows[i].req, DirRows[i].preset, DirRows[i].rsp);

    // long stall with rpm threshold, delay and timeout at full scale and duty threshold at zero, then the fan recovers
    wait_drained();
    write_config(fcp_pkg::Sat16, 7'd0, fcp_pkg::Sat16, fcp_pkg::Sat16);
    r = '{fcp_pkg::OpSetTemp, 9'd60, 8'd0, 16'd0};
    send_req(r, 1'b0, '0);
    r.operation = fcp_pkg::OpTick;
    repeat (LongTicks) send_req(r, 1'b0, '0);
    r.fan_rpm = fcp_pkg::Sat16;
    repeat (3) send_req(r, 1'b0, '0);

    run_phase(IdleNone, 16'd3, 7'd30, 16'd100, 16'd4);
    run_phase(IdleSender, 16'd0, 7'd0, fcp_pkg::Sat16, 16'd0);
    run_phase(IdleReceiver, fcp_pkg::Sat16, 7'd100, 16'd0, fcp_pkg::Sat16);
    run_phase(IdleBoth, 16'd1, 7'd127, 16'd2000, 16'd1);
    run_phase(IdleSender, 16'($urandom_range(1, 12)), 7'($urandom_range(0, 110)),
              16'($urandom_range(1, 3000)), 16'($urandom_range(0, 20)));
    run_phase(IdleReceiver, 16'($urandom_range(1, 12)), 7'($urandom_range(0, 110)),
              16'($urandom_range(1, 3000)), 16'($urandom_range(0, 20)));
    wait_drained();

    $display("checked %0d responses over %0d cycles: directed table, long stall, six configs",
             n_checked, n_cycles);
    $display("saw %0d with stall fault and %0d duty rewrites; %0d mismatches, %0d left pending",
             n_faults, n_rewrites, n_mismatch, pending_status_q.size());
    if (n_mismatch == 0 && pending_status_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/fcp_pkg.sv
hdl/fcp_if.sv
hdl/fcp_core.sv
hdl/fan_curve_pwm_with_stall_fault.sv
test/tb_fan_curve_pwm_with_stall_fault.sv
